// File: rtl/qe_pkg.sv
// Package for the quaternion to Euler angle converter: word types, widths,
// and the CORDIC arctangent table. Used by every module in this block.
package qe_pkg;

    localparam int ANGLE_ITERATIONS_DEF = 16;
    localparam int ATAN_TABLE_SIZE = 24;
    localparam int OPW = 38;
    localparam int ACCW = 32;
    localparam int SQRT_BITS = 29;
    localparam int RADW = 59;
    localparam int PROD_STAGES = 3;

    typedef logic signed [OPW-1:0] opw_t;

    localparam opw_t Q28_ONE = opw_t'(64'sd268435456);

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } out_word_t;

    typedef struct packed {
        opw_t roll_y;
        opw_t roll_x;
        opw_t pitch_y;
        opw_t pitch_x;
        opw_t yaw_y;
        opw_t yaw_x;
        logic reproject;
    } axis_ops_t;

    function automatic logic [ACCW-1:0] atan_entry(input logic [4:0] idx);
        logic [ACCW-1:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/qe_products.sv
// Product and operand stages: quaternion products, atan2 operands and the
// squared cosine term for the direct yaw. Depends on qe_pkg.
module qe_products (
    input  logic              clk,
    input  logic              en,
    input  qe_pkg::in_word_t  in_word,
    input  logic              reproject,
    output qe_pkg::axis_ops_t ops,
    output logic [qe_pkg::RADW-1:0] cos_sq
);
    import qe_pkg::*;

    logic signed [31:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [31:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic               mode_reg;
    axis_ops_t          ops_b_next, ops_b_reg, ops_c_reg;
    logic [RADW-1:0]    cos_sq_reg;
    logic signed [29:0] s_short;
    logic signed [59:0] s_sq;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg   <= in_word.quat_x * in_word.quat_x;
            yy_reg   <= in_word.quat_y * in_word.quat_y;
            zz_reg   <= in_word.quat_z * in_word.quat_z;
            ww_reg   <= in_word.quat_w * in_word.quat_w;
            xy_reg   <= in_word.quat_x * in_word.quat_y;
            xz_reg   <= in_word.quat_x * in_word.quat_z;
            yz_reg   <= in_word.quat_y * in_word.quat_z;
            wx_reg   <= in_word.quat_w * in_word.quat_x;
            wy_reg   <= in_word.quat_w * in_word.quat_y;
            wz_reg   <= in_word.quat_w * in_word.quat_z;
            mode_reg <= reproject;
        end
    end

    always_comb
    begin
        opw_t xx, yy, zz, ww, xy, xz, yz, wx, wy, wz, s;
        xx = opw_t'(xx_reg);
        yy = opw_t'(yy_reg);
        zz = opw_t'(zz_reg);
        ww = opw_t'(ww_reg);
        xy = opw_t'(xy_reg);
        xz = opw_t'(xz_reg);
        yz = opw_t'(yz_reg);
        wx = opw_t'(wx_reg);
        wy = opw_t'(wy_reg);
        wz = opw_t'(wz_reg);
        s = -((xz - wy) <<< 1);
        if (s > Q28_ONE)
            s = Q28_ONE;
        if (s < -Q28_ONE)
            s = -Q28_ONE;
        ops_b_next.reproject = mode_reg;
        ops_b_next.roll_y = (xy + wz) <<< 1;
        ops_b_next.pitch_y = (yz + wx) <<< 1;
        if (mode_reg)
        begin
            ops_b_next.roll_x  = Q28_ONE - ((yy + zz) <<< 1);
            ops_b_next.pitch_x = Q28_ONE - ((xx + zz) <<< 1);
            ops_b_next.yaw_y   = (xz + wy) <<< 1;
            ops_b_next.yaw_x   = Q28_ONE - ((xx + yy) <<< 1);
        end
        else
        begin
            ops_b_next.roll_x  = ww + xx - yy - zz;
            ops_b_next.pitch_x = ww - xx - yy + zz;
            ops_b_next.yaw_y   = s;
            ops_b_next.yaw_x   = '0;
        end
    end

    assign s_short = ops_b_reg.yaw_y[29:0];
    assign s_sq = s_short * s_short;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ops_b_reg  <= ops_b_next;
            ops_c_reg  <= ops_b_reg;
            cos_sq_reg <= (RADW'(1) << 56) - s_sq[RADW-1:0];
        end
    end

    assign ops = ops_c_reg;
    assign cos_sq = cos_sq_reg;

endmodule

// File: rtl/qe_sqrt.sv
// Pipelined integer square root, one result bit per stage, giving the
// cosine for the direct yaw; other operands ride alongside. Depends on qe_pkg.
module qe_sqrt (
    input  logic                    clk,
    input  logic                    en,
    input  qe_pkg::axis_ops_t       ops_in,
    input  logic [qe_pkg::RADW-1:0] rad_in,
    output qe_pkg::axis_ops_t       ops_out
);
    import qe_pkg::*;

    logic [RADW-1:0]      rem_reg  [SQRT_BITS];
    logic [SQRT_BITS-1:0] root_reg [SQRT_BITS];
    axis_ops_t            side_reg [SQRT_BITS];

    genvar k;
    generate
        for (k = 0; k < SQRT_BITS; k++)
        begin : g_step
            localparam int B = SQRT_BITS - 1 - k;
            logic [RADW-1:0]      rem_prev, inc;
            logic [SQRT_BITS-1:0] root_prev;
            axis_ops_t            side_prev;
            if (k == 0)
            begin : g_first
                assign rem_prev  = rad_in;
                assign root_prev = '0;
                assign side_prev = ops_in;
            end
            else
            begin : g_next
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign side_prev = side_reg[k-1];
            end
            assign inc = (RADW'(root_prev) << (B + 1)) + (RADW'(1) << (2 * B));
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[k] <= side_prev;
                    if (rem_prev >= inc)
                    begin
                        rem_reg[k]  <= rem_prev - inc;
                        root_reg[k] <= root_prev | (SQRT_BITS'(1) << B);
                    end
                    else
                    begin
                        rem_reg[k]  <= rem_prev;
                        root_reg[k] <= root_prev;
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        ops_out = side_reg[SQRT_BITS-1];
        if (!side_reg[SQRT_BITS-1].reproject)
            ops_out.yaw_x = opw_t'({1'b0, root_reg[SQRT_BITS-1]});
    end

endmodule

// File: rtl/qe_cordic.sv
// One pipelined CORDIC vectoring lane computing atan2 as a 16-bit binary
// angle, one micro-rotation per stage. Depends on qe_pkg.
module qe_cordic #(
    parameter int ITER = qe_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  qe_pkg::opw_t       y_in,
    input  qe_pkg::opw_t       x_in,
    output logic signed [15:0] angle
);
    import qe_pkg::*;

    opw_t            x_pre_reg, y_pre_reg;
    logic [ACCW-1:0] acc_pre_reg;
    logic            zero_pre_reg;
    opw_t            x_reg    [ITER];
    opw_t            y_reg    [ITER];
    logic [ACCW-1:0] acc_reg  [ITER];
    logic            zero_reg [ITER];
    logic [15:0]     angle_reg;
    logic [ACCW-1:0] rounded;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_pre_reg <= (x_in == '0) && (y_in == '0);
            if (x_in < 0 && y_in >= 0)
            begin
                x_pre_reg   <= y_in;
                y_pre_reg   <= -x_in;
                acc_pre_reg <= 32'h4000_0000;
            end
            else if (x_in < 0)
            begin
                x_pre_reg   <= -y_in;
                y_pre_reg   <= x_in;
                acc_pre_reg <= 32'hC000_0000;
            end
            else
            begin
                x_pre_reg   <= x_in;
                y_pre_reg   <= y_in;
                acc_pre_reg <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < ITER; i++)
        begin : g_iter
            opw_t            x_prev, y_prev;
            logic [ACCW-1:0] acc_prev;
            logic            zero_prev;
            if (i == 0)
            begin : g_first
                assign x_prev    = x_pre_reg;
                assign y_prev    = y_pre_reg;
                assign acc_prev  = acc_pre_reg;
                assign zero_prev = zero_pre_reg;
            end
            else
            begin : g_next
                assign x_prev    = x_reg[i-1];
                assign y_prev    = y_reg[i-1];
                assign acc_prev  = acc_reg[i-1];
                assign zero_prev = zero_reg[i-1];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    zero_reg[i] <= zero_prev;
                    if (y_prev >= 0)
                    begin
                        x_reg[i]   <= x_prev + (y_prev >>> i);
                        y_reg[i]   <= y_prev - (x_prev >>> i);
                        acc_reg[i] <= acc_prev + atan_entry(5'(i));
                    end
                    else
                    begin
                        x_reg[i]   <= x_prev - (y_prev >>> i);
                        y_reg[i]   <= y_prev + (x_prev >>> i);
                        acc_reg[i] <= acc_prev - atan_entry(5'(i));
                    end
                end
            end
        end
    endgenerate

    assign rounded = acc_reg[ITER-1] + 32'h0000_8000;

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= zero_reg[ITER-1] ? 16'd0 : rounded[31:16];
    end

    assign angle = angle_reg;

endmodule

// File: rtl/quaternion_to_euler_angles.sv
// Quaternion to Euler angle converter, top level.
// Depends on qe_pkg, qe_products, qe_sqrt and qe_cordic.
//
// The input channel takes one quaternion word (x, y, z, w in signed Q1.14)
// on in_valid with in_stall low. The output channel returns one word of
// roll, pitch and yaw as signed binary angles, 32768 standing for pi.
// One word is accepted in every cycle and one result leaves per cycle
// while out_stall does not hold the pipeline. The pipeline has three
// product and operand stages, one stage per root bit of the yaw square
// root, a pre-rotation stage, one stage per CORDIC micro-rotation and a
// rounding stage. The mode register mode_reg is written with cfg_write
// and cfg_data; the user must write it only while the block is idle,
// which the block does not enforce. It resets to the direct formulas.
// Reset clears all valid bits, so no result leaves until words arrive.
// When out_stall holds a waiting result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
module quaternion_to_euler_angles #(
    parameter int ANGLE_ITERATIONS = qe_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  qe_pkg::in_word_t  in_word,
    input  logic              cfg_write,
    input  logic              cfg_data,
    output logic              out_valid,
    input  logic              out_stall,
    output qe_pkg::out_word_t out_word
);
    import qe_pkg::*;

    localparam int LAT = PROD_STAGES + SQRT_BITS + ANGLE_ITERATIONS + 2;

    logic            mode_reg;
    logic [LAT-1:0]  valid_reg;
    logic            en;
    axis_ops_t       ops_prod, ops_sqrt;
    logic [RADW-1:0] cos_sq;

    assign en = !(valid_reg[LAT-1] && out_stall);
    assign in_stall = !en;
    assign out_valid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            if (cfg_write)
                mode_reg <= cfg_data;
            if (en)
                valid_reg <= {valid_reg[LAT-2:0], in_valid};
        end
    end

    qe_products u_products (
        .clk       (clk),
        .en        (en),
        .in_word   (in_word),
        .reproject (mode_reg),
        .ops       (ops_prod),
        .cos_sq    (cos_sq)
    );

    qe_sqrt u_sqrt (
        .clk     (clk),
        .en      (en),
        .ops_in  (ops_prod),
        .rad_in  (cos_sq),
        .ops_out (ops_sqrt)
    );

    qe_cordic #(.ITER(ANGLE_ITERATIONS)) u_roll (
        .clk   (clk),
        .en    (en),
        .y_in  (ops_sqrt.roll_y),
        .x_in  (ops_sqrt.roll_x),
        .angle (out_word.roll_angle)
    );

    qe_cordic #(.ITER(ANGLE_ITERATIONS)) u_pitch (
        .clk   (clk),
        .en    (en),
        .y_in  (ops_sqrt.pitch_y),
        .x_in  (ops_sqrt.pitch_x),
        .angle (out_word.pitch_angle)
    );

    qe_cordic #(.ITER(ANGLE_ITERATIONS)) u_yaw (
        .clk   (clk),
        .en    (en),
        .y_in  (ops_sqrt.yaw_y),
        .x_in  (ops_sqrt.yaw_x),
        .angle (out_word.yaw_angle)
    );

endmodule

// File: tb/qe_checker.sv
// Checker for the quaternion to Euler angle converter: watches both channels
// and the mode register, predicts each angle word and compares it.
// Depends on qe_pkg for the word types.
`timescale 1ns / 100ps

module qe_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  qe_pkg::in_word_t  in_word,
    input  logic              cfg_write,
    input  logic              cfg_data,
    input  logic              out_valid,
    input  logic              out_stall,
    input  qe_pkg::out_word_t out_word,
    output int                fails,
    output int                pending
);
    import qe_pkg::*;

    localparam int  ITERATIONS = ANGLE_ITERATIONS_DEF;
    localparam longint UNIT = 64'sd268435456;

    logic      reproject;
    out_word_t angle_q[$];

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] bin_angle(input longint yv, input longint xv);
        logic [31:0] acc;
        longint      xr;
        longint      yr;
        longint      dx;
        longint      dy;
        longint      t;
        logic [31:0] rounded;
        acc = '0;
        xr = xv;
        yr = yv;
        if (xr == 0 && yr == 0)
        begin
            return 16'd0;
        end
        if (xr < 0)
        begin
            t = xr;
            if (yr >= 0)
            begin
                xr = yr;
                yr = -t;
                acc = 32'h4000_0000;
            end
            else
            begin
                xr = -yr;
                yr = t;
                acc = 32'hC000_0000;
            end
        end
        for (int i = 0; i < ITERATIONS && i < ATAN_TABLE_SIZE; i++)
        begin
            dx = yr >>> i;
            dy = xr >>> i;
            if (yr >= 0)
            begin
                xr = xr + dx;
                yr = yr - dy;
                acc = acc + atan_arc(i);
            end
            else
            begin
                xr = xr - dx;
                yr = yr + dy;
                acc = acc - atan_arc(i);
            end
        end
        rounded = acc + 32'h8000;
        return rounded[31:16];
    endfunction

    function automatic logic [31:0] atan_arc(input int i);
        logic [31:0] arcs [24];
        arcs = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                 32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                 32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
                 32'd166886, 32'd83443, 32'd41722, 32'd20861,
                 32'd10430, 32'd5215, 32'd2608, 32'd1304,
                 32'd652, 32'd326, 32'd163, 32'd81};
        return arcs[i];
    endfunction

    function automatic out_word_t euler_angles(input in_word_t q, input logic mode);
        longint    x;
        longint    y;
        longint    z;
        longint    w;
        longint    s;
        longint unsigned c2;
        out_word_t r;
        x = q.quat_x;
        y = q.quat_y;
        z = q.quat_z;
        w = q.quat_w;
        if (mode)
        begin
            r.roll_angle  = bin_angle(2 * (x*y + w*z), UNIT - 2 * (y*y + z*z));
            r.pitch_angle = bin_angle(2 * (y*z + w*x), UNIT - 2 * (x*x + z*z));
            r.yaw_angle   = bin_angle(2 * (x*z + w*y), UNIT - 2 * (x*x + y*y));
        end
        else
        begin
            r.roll_angle  = bin_angle(2 * (x*y + w*z), w*w + x*x - y*y - z*z);
            r.pitch_angle = bin_angle(2 * (y*z + w*x), w*w - x*x - y*y + z*z);
            s = -2 * (x*z - w*y);
            if (s > UNIT)
            begin
                s = UNIT;
            end
            if (s < -UNIT)
            begin
                s = -UNIT;
            end
            c2 = longint'(UNIT * UNIT) - longint'(s * s);
            r.yaw_angle = bin_angle(s, longint'(root_floor(c2)));
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reproject <= 1'b0;
        end
        else if (cfg_write)
        begin
            reproject <= cfg_data;
        end
    end

    initial
    begin
        fails = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                angle_q.insert(angle_q.size(), euler_angles(in_word, reproject));
            end
            if (out_valid && !out_stall)
            begin
                if (angle_q.size() == 0)
                begin
                    $error("angle word with none expected");
                    fails++;
                end
                else
                begin
                    exp_w = angle_q.pop_front();
                    if (out_word.roll_angle !== exp_w.roll_angle)
                    begin
                        $error("roll_angle: expected %0d, got %0d",
                               exp_w.roll_angle, out_word.roll_angle);
                        fails++;
                    end
                    if (out_word.pitch_angle !== exp_w.pitch_angle)
                    begin
                        $error("pitch_angle: expected %0d, got %0d",
                               exp_w.pitch_angle, out_word.pitch_angle);
                        fails++;
                    end
                    if (out_word.yaw_angle !== exp_w.yaw_angle)
                    begin
                        $error("yaw_angle: expected %0d, got %0d",
                               exp_w.yaw_angle, out_word.yaw_angle);
                        fails++;
                    end
                end
            end
            pending = angle_q.size();
        end
    end

endmodule

// File: tb/testbench.sv
// Top of the quaternion to Euler angle testbench: clock, reset, stimulus,
// mode changes and verdict. Depends on qe_pkg, the block and qe_checker.
`timescale 1ns / 100ps

module testbench;
    import qe_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_word;
    logic      cfg_write;
    logic      cfg_data;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_word;
    int        fails;
    int        pending;
    logic      flood;

    quaternion_to_euler_angles DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    qe_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
        begin
            return $urandom_range(10, 60);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    function automatic in_word_t random_quat();
        in_word_t q;
        real      c [4];
        real      norm;
        int       kind;
        kind = $urandom_range(0, 9);
        if (kind < 6)
        begin
            norm = 0.0;
            for (int i = 0; i < 4; i++)
            begin
                c[i] = real'($urandom_range(0, 65535)) - 32768.0;
                norm = norm + c[i] * c[i];
            end
            norm = $sqrt(norm);
            if (norm < 1.0)
            begin
                norm = 1.0;
            end
            q.quat_x = 16'(int'(c[0] / norm * 16384.0));
            q.quat_y = 16'(int'(c[1] / norm * 16384.0));
            q.quat_z = 16'(int'(c[2] / norm * 16384.0));
            q.quat_w = 16'(int'(c[3] / norm * 16384.0));
        end
        else if (kind < 8)
        begin
            q.quat_x = 16'($urandom_range(0, 32768) - 16384);
            q.quat_y = 16'($urandom_range(0, 32768) - 16384);
            q.quat_z = 16'($urandom_range(0, 32768) - 16384);
            q.quat_w = 16'($urandom_range(0, 32768) - 16384);
        end
        else if (kind == 8)
        begin
            q = in_word_t'({$urandom, $urandom});
        end
        else
        begin
            q.quat_x = 16'($urandom_range(0, 8) - 4);
            q.quat_y = 16'($urandom_range(0, 8) - 4);
            q.quat_z = 16'($urandom_range(0, 8) - 4);
            q.quat_w = 16'($urandom_range(0, 8) - 4);
        end
        return q;
    endfunction

    task automatic send_word(input in_word_t q, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= q;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        if (in_valid)
        begin
            in_valid <= 1'b0;
        end
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_write <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic directed_words();
        in_word_t list [$];
        list = '{
            in_word_t'({16'sd0, 16'sd0, 16'sd0, 16'sd0}),
            in_word_t'({16'sd0, 16'sd0, 16'sd0, 16'sd16384}),
            in_word_t'({16'sd0, 16'sd0, 16'sd16384, 16'sd0}),
            in_word_t'({16'sd16384, 16'sd0, 16'sd0, 16'sd0}),
            in_word_t'({16'sd0, 16'sd16384, 16'sd0, 16'sd0}),
            in_word_t'({16'sd0, 16'sd0, 16'sd0, -16'sd16384}),
            in_word_t'({-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384}),
            in_word_t'({16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384}),
            in_word_t'({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}),
            in_word_t'({16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}),
            in_word_t'({16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000}),
            in_word_t'({16'sd0, 16'sd16384, 16'sd0, 16'sd16384}),
            in_word_t'({16'sd0, -16'sd16384, 16'sd0, 16'sd16384}),
            in_word_t'({16'sd0, 16'sd11585, 16'sd0, 16'sd11585}),
            in_word_t'({16'sd11585, 16'sd0, 16'sd11585, 16'sd0}),
            in_word_t'({16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192}),
            in_word_t'({16'sd0, 16'sd0, 16'sd1, 16'sd0}),
            in_word_t'({16'sd1, 16'sd0, 16'sd0, -16'sd1}),
            in_word_t'({-16'sd16384, 16'sd0, 16'sd0, 16'sd0}),
            in_word_t'({16'sd0, 16'sd0, -16'sd16384, 16'sd0})
        };
        foreach (list[i])
        begin
            send_word(list[i], gap_len());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_write = 1'b0;
        cfg_data = 1'b0;
        flood = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();
        flood = 1'b1;
        for (int i = 0; i < 200; i++)
        begin
            send_word(random_quat(), 0);
        end
        flood = 1'b0;
        for (int i = 0; i < 150; i++)
        begin
            send_word(random_quat(), gap_len());
        end
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_mode(phase % 2 == 0);
            directed_words();
            for (int i = 0; i < 230; i++)
            begin
                send_word(random_quat(), gap_len());
            end
            drain();
        end

        repeat (60) @(posedge clk);
        if (fails == 0 && pending == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        bit long_hold_done;
        int run;
        int pick;
        out_stall = 1'b0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (flood && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            run = $urandom_range(10, 60);
            for (int i = 0; i < run; i++)
            begin
                if (pick < 35)
                begin
                    out_stall <= 1'b0;
                end
                else if (pick < 95)
                begin
                    out_stall <= ($urandom_range(0, 9) < 3);
                end
                else
                begin
                    out_stall <= 1'b1;
                end
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
